// File: hw/rtl/rtprx_pkg.sv
// Shared types and constants for the RTP receive statistics block.
`default_nettype none

package rtprx_pkg;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CLOCK_RATE = 1'd0;

    localparam int CLOCK_RATE_W = 20;
    localparam logic [CLOCK_RATE_W-1:0] CLOCK_RATE_RESET = 20'd90000;

    // Arithmetic constants.
    localparam logic [19:0] USEC_PER_SEC     = 20'd1000000;
    localparam logic [21:0] ONE_SEC_US_W22   = 22'd1000000;
    localparam logic [21:0] TWO_SEC_US_W22   = 22'd2000000;
    localparam logic [39:0] HALF_SEC_US      = 40'd500000;
    // floor(2^40 / 1e6): reciprocal used to divide by one million.
    localparam logic [20:0] RECIP_1E6        = 21'd1099511;
    localparam logic [31:0] NTP_UNIX_OFFSET  = 32'h83AA_7E80;
    localparam logic [13:0] SR_USEC_MULT     = 14'd15625;
    localparam logic [45:0] SR_USEC_ROUND    = 46'h0000_0200_0000;
    localparam logic [15:0] SEQ_WRAP_THRESH  = 16'h8000;
    localparam logic [31:0] GAP_MIN_RESET    = 32'h7FFF_FFFF;
    localparam logic [32:0] JITTER_ROUND     = 33'd8;

    // Queue sizes.
    localparam int IQ_DEPTH = 2;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_SR   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq_num;
        logic [31:0] rtp_timestamp;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
        logic [31:0] ntp_seconds;
        logic [31:0] ntp_fraction;
    } in_item_t;

    typedef struct packed {
        logic [31:0] highest_ext_seq;
        logic [31:0] total_packets;
        logic [31:0] jitter_x16;
        logic [31:0] min_gap_us;
        logic [31:0] max_gap_us;
        logic [63:0] gap_total_us;
        logic        synced;
        logic [31:0] sync_sec;
        logic [19:0] sync_usec;
        logic [31:0] sync_rtp_ts;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtprx_front.sv
// Front end: accepts event beats, classifies them and queues them for execution.
`default_nettype none

module rtprx_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  operation,
    input  wire logic [15:0]           seq_num,
    input  wire logic [31:0]           rtp_timestamp,
    input  wire logic [31:0]           now_sec,
    input  wire logic [19:0]           now_usec,
    input  wire logic [31:0]           ntp_seconds,
    input  wire logic [31:0]           ntp_fraction,
    output logic                       item_valid,
    output rtprx_pkg::in_item_t        item,
    input  wire logic                  item_take
);

    rtprx_pkg::in_item_t                 q_mem_reg [rtprx_pkg::IQ_DEPTH];
    logic [rtprx_pkg::IQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rtprx_pkg::IQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rtprx_pkg::IQ_CNT_W-1:0]      count_reg, count_next;
    rtprx_pkg::in_item_t                 new_item;
    logic                                do_push;
    logic                                do_take;

    always_comb
    begin
        new_item.kind          = operation ? rtprx_pkg::KIND_SR : rtprx_pkg::KIND_DATA;
        new_item.seq_num       = seq_num;
        new_item.rtp_timestamp = rtp_timestamp;
        new_item.now_sec       = now_sec;
        new_item.now_usec      = now_usec;
        new_item.ntp_seconds   = ntp_seconds;
        new_item.ntp_fraction  = ntp_fraction;
    end

    assign full       = (count_reg == rtprx_pkg::IQ_CNT_W'(rtprx_pkg::IQ_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({do_push, do_take})
            2'b10:   count_next = count_reg + rtprx_pkg::IQ_CNT_W'(1);
            2'b01:   count_next = count_reg - rtprx_pkg::IQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rtprx_exec.sv
// Back end: multi-cycle sequencer that updates the stream statistics.
`default_nettype none

module rtprx_exec (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [rtprx_pkg::CLOCK_RATE_W-1:0]    clock_rate,
    input  wire logic                                  item_valid,
    input  wire rtprx_pkg::in_item_t                   item,
    output logic                                       item_take,
    output logic                                       res_push,
    input  wire logic                                  res_full,
    output rtprx_pkg::result_t                         result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_D5,
        ST_EMIT
    } state_t;

    state_t       state_reg, state_next;

    // Statistics state.
    logic         seen_first_reg, seen_first_next;
    logic [31:0]  ext_seq_reg, ext_seq_next;
    logic [31:0]  packet_count_reg, packet_count_next;
    logic [31:0]  prev_transit_reg, prev_transit_next;
    logic         transit_valid_reg, transit_valid_next;
    logic [31:0]  prev_rtp_ts_reg, prev_rtp_ts_next;
    logic [31:0]  jitter_acc_reg, jitter_acc_next;
    logic [31:0]  last_arr_sec_reg, last_arr_sec_next;
    logic [19:0]  last_arr_usec_reg, last_arr_usec_next;
    logic         arrival_valid_reg, arrival_valid_next;
    logic [31:0]  gap_min_reg, gap_min_next;
    logic [31:0]  gap_max_reg, gap_max_next;
    logic [63:0]  gap_sum_reg, gap_sum_next;
    logic         sync_flag_reg, sync_flag_next;
    logic [31:0]  sync_seconds_reg, sync_seconds_next;
    logic [19:0]  sync_micros_reg, sync_micros_next;
    logic [31:0]  sync_ts_reg, sync_ts_next;

    // Working registers of the packet in flight.
    logic [31:0]  eff_ext_reg, eff_ext_next;
    logic [31:0]  cand_reg, cand_next;
    logic [39:0]  p_usec_reg, p_usec_next;
    logic [31:0]  base_reg, base_next;
    logic [31:0]  dsec_reg, dsec_next;
    logic [31:0]  dusec_reg, dusec_next;
    logic         had_arr_reg, had_arr_next;
    logic         jit_en_reg, jit_en_next;
    logic [20:0]  q_est_reg, q_est_next;
    logic [31:0]  gap_reg, gap_next;
    logic [28:0]  decay_reg, decay_next;
    logic [21:0]  rem_reg, rem_next;
    logic [31:0]  shrink_reg, shrink_next;
    logic [31:0]  transit_reg, transit_next;
    logic [31:0]  mag_reg, mag_next;

    // Combinational helpers.
    logic         load;
    logic [31:0]  eff_ext;
    logic [15:0]  seq_diff;
    logic         wrap;
    logic [15:0]  cycle_hi;
    logic [39:0]  usec_prod;
    logic [31:0]  sec_prod;
    logic [45:0]  sr_prod;
    logic [52:0]  recip_prod;
    logic [31:0]  ahead;
    logic [39:0]  q_scaled;
    logic [32:0]  round_sum;
    logic [1:0]   corr;
    logic [31:0]  ref_transit;
    logic [31:0]  d_pos;
    logic [31:0]  d_neg;
    logic [32:0]  jit_sum;

    assign load      = item_valid &&
                       (state_reg == ST_IDLE || (state_reg == ST_EMIT && !res_full));
    assign item_take = load;
    assign res_push  = (state_reg == ST_EMIT) && !res_full;

    always_comb
    begin
        result.highest_ext_seq = ext_seq_reg;
        result.total_packets   = packet_count_reg;
        result.jitter_x16      = jitter_acc_reg;
        result.min_gap_us      = gap_min_reg;
        result.max_gap_us      = gap_max_reg;
        result.gap_total_us    = gap_sum_reg;
        result.synced          = sync_flag_reg;
        result.sync_sec        = sync_seconds_reg;
        result.sync_usec       = sync_micros_reg;
        result.sync_rtp_ts     = sync_ts_reg;
    end

    // Arithmetic used by the individual steps.
    always_comb
    begin
        eff_ext    = seen_first_reg ? ext_seq_reg : {16'b0, item.seq_num};
        seq_diff   = eff_ext[15:0] - item.seq_num;
        wrap       = (eff_ext[15:0] > item.seq_num) && (seq_diff > rtprx_pkg::SEQ_WRAP_THRESH);
        cycle_hi   = eff_ext[31:16] + {15'b0, wrap};
        usec_prod  = {20'b0, clock_rate} * {20'b0, item.now_usec};
        sec_prod   = {12'b0, clock_rate} * item.now_sec;
        sr_prod    = {14'b0, item.ntp_fraction} * {32'b0, rtprx_pkg::SR_USEC_MULT};
        recip_prod = {21'b0, p_usec_reg[39:8]} * {32'b0, rtprx_pkg::RECIP_1E6};
        ahead      = cand_reg - eff_ext_reg;
        q_scaled   = {19'b0, q_est_reg} * {20'b0, rtprx_pkg::USEC_PER_SEC};
        round_sum  = {1'b0, jitter_acc_reg} + rtprx_pkg::JITTER_ROUND;
        if (rem_reg >= rtprx_pkg::TWO_SEC_US_W22)
        begin
            corr = 2'd2;
        end
        else if (rem_reg >= rtprx_pkg::ONE_SEC_US_W22)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
        // The first transit seeds the reference, which makes the difference zero.
        ref_transit = transit_valid_reg ? prev_transit_reg : transit_reg;
        d_pos       = transit_reg - ref_transit;
        d_neg       = ref_transit - transit_reg;
        jit_sum     = {1'b0, shrink_reg} + {1'b0, mag_reg};
    end

    always_comb
    begin
        state_next         = state_reg;
        seen_first_next    = seen_first_reg;
        ext_seq_next       = ext_seq_reg;
        packet_count_next  = packet_count_reg;
        prev_transit_next  = prev_transit_reg;
        transit_valid_next = transit_valid_reg;
        prev_rtp_ts_next   = prev_rtp_ts_reg;
        jitter_acc_next    = jitter_acc_reg;
        last_arr_sec_next  = last_arr_sec_reg;
        last_arr_usec_next = last_arr_usec_reg;
        arrival_valid_next = arrival_valid_reg;
        gap_min_next       = gap_min_reg;
        gap_max_next       = gap_max_reg;
        gap_sum_next       = gap_sum_reg;
        sync_flag_next     = sync_flag_reg;
        sync_seconds_next  = sync_seconds_reg;
        sync_micros_next   = sync_micros_reg;
        sync_ts_next       = sync_ts_reg;

        eff_ext_next = eff_ext_reg;
        cand_next    = cand_reg;
        p_usec_next  = p_usec_reg;
        base_next    = base_reg;
        dsec_next    = dsec_reg;
        dusec_next   = dusec_reg;
        had_arr_next = had_arr_reg;
        jit_en_next  = jit_en_reg;
        q_est_next   = q_est_reg;
        gap_next     = gap_reg;
        decay_next   = decay_reg;
        rem_next     = rem_reg;
        shrink_next  = shrink_reg;
        transit_next = transit_reg;
        mag_next     = mag_reg;

        if (load)
        begin
            if (item.kind == rtprx_pkg::KIND_SR)
            begin
                sync_ts_next      = item.rtp_timestamp;
                sync_seconds_next = item.ntp_seconds - rtprx_pkg::NTP_UNIX_OFFSET;
                sync_micros_next  = 20'((sr_prod + rtprx_pkg::SR_USEC_ROUND) >> 26);
                sync_flag_next    = 1'b1;
                state_next        = ST_EMIT;
            end
            else
            begin
                eff_ext_next       = eff_ext;
                cand_next          = {cycle_hi, item.seq_num};
                seen_first_next    = 1'b1;
                packet_count_next  = packet_count_reg + 32'd1;
                p_usec_next        = usec_prod + rtprx_pkg::HALF_SEC_US;
                base_next          = sec_prod - item.rtp_timestamp;
                dsec_next          = item.now_sec - last_arr_sec_reg;
                dusec_next         = {12'b0, item.now_usec} - {12'b0, last_arr_usec_reg};
                had_arr_next       = arrival_valid_reg;
                last_arr_sec_next  = item.now_sec;
                last_arr_usec_next = item.now_usec;
                arrival_valid_next = 1'b1;
                jit_en_next        = (item.rtp_timestamp != prev_rtp_ts_reg);
                prev_rtp_ts_next   = item.rtp_timestamp;
                state_next         = ST_D1;
            end
        end
        else if (state_reg == ST_EMIT && !res_full)
        begin
            state_next = ST_IDLE;
        end

        case (state_reg)
            ST_D1:
            begin
                q_est_next = recip_prod[52:32];
                gap_next   = 32'(dsec_reg * {12'b0, rtprx_pkg::USEC_PER_SEC}) + dusec_reg;
                decay_next = round_sum[32:4];
                if (ahead != 32'd0 && !ahead[31])
                begin
                    ext_seq_next = cand_reg;
                end
                else
                begin
                    ext_seq_next = eff_ext_reg;
                end
                state_next = ST_D2;
            end
            ST_D2:
            begin
                rem_next    = p_usec_reg[21:0] - q_scaled[21:0];
                shrink_next = jitter_acc_reg - {3'b0, decay_reg};
                if (had_arr_reg)
                begin
                    if (gap_reg > gap_max_reg)
                    begin
                        gap_max_next = gap_reg;
                    end
                    if (gap_reg < gap_min_reg)
                    begin
                        gap_min_next = gap_reg;
                    end
                    gap_sum_next = gap_sum_reg + {32'b0, gap_reg};
                end
                state_next = ST_D3;
            end
            ST_D3:
            begin
                transit_next = base_reg + {11'b0, q_est_reg} + {30'b0, corr};
                state_next   = ST_D4;
            end
            ST_D4:
            begin
                mag_next = d_pos[31] ? d_neg : d_pos;
                if (jit_en_reg)
                begin
                    prev_transit_next  = transit_reg;
                    transit_valid_next = 1'b1;
                end
                state_next = ST_D5;
            end
            ST_D5:
            begin
                if (jit_en_reg)
                begin
                    jitter_acc_next = jit_sum[32] ? 32'hFFFF_FFFF : jit_sum[31:0];
                end
                state_next = ST_EMIT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            seen_first_reg    <= 1'b0;
            ext_seq_reg       <= '0;
            packet_count_reg  <= '0;
            prev_transit_reg  <= '0;
            transit_valid_reg <= 1'b0;
            prev_rtp_ts_reg   <= '0;
            jitter_acc_reg    <= '0;
            last_arr_sec_reg  <= '0;
            last_arr_usec_reg <= '0;
            arrival_valid_reg <= 1'b0;
            gap_min_reg       <= rtprx_pkg::GAP_MIN_RESET;
            gap_max_reg       <= '0;
            gap_sum_reg       <= '0;
            sync_flag_reg     <= 1'b0;
            sync_seconds_reg  <= '0;
            sync_micros_reg   <= '0;
            sync_ts_reg       <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            seen_first_reg    <= seen_first_next;
            ext_seq_reg       <= ext_seq_next;
            packet_count_reg  <= packet_count_next;
            prev_transit_reg  <= prev_transit_next;
            transit_valid_reg <= transit_valid_next;
            prev_rtp_ts_reg   <= prev_rtp_ts_next;
            jitter_acc_reg    <= jitter_acc_next;
            last_arr_sec_reg  <= last_arr_sec_next;
            last_arr_usec_reg <= last_arr_usec_next;
            arrival_valid_reg <= arrival_valid_next;
            gap_min_reg       <= gap_min_next;
            gap_max_reg       <= gap_max_next;
            gap_sum_reg       <= gap_sum_next;
            sync_flag_reg     <= sync_flag_next;
            sync_seconds_reg  <= sync_seconds_next;
            sync_micros_reg   <= sync_micros_next;
            sync_ts_reg       <= sync_ts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eff_ext_reg <= eff_ext_next;
        cand_reg    <= cand_next;
        p_usec_reg  <= p_usec_next;
        base_reg    <= base_next;
        dsec_reg    <= dsec_next;
        dusec_reg   <= dusec_next;
        had_arr_reg <= had_arr_next;
        jit_en_reg  <= jit_en_next;
        q_est_reg   <= q_est_next;
        gap_reg     <= gap_next;
        decay_reg   <= decay_next;
        rem_reg     <= rem_next;
        shrink_reg  <= shrink_next;
        transit_reg <= transit_next;
        mag_reg     <= mag_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rtprx_result_q.sv
// Result queue that holds finished statistics beats until they are popped.
`default_nettype none

module rtprx_result_q (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  res_push,
    output logic                       res_full,
    input  wire rtprx_pkg::result_t    res_in,
    output logic                       empty,
    input  wire logic                  pop,
    output rtprx_pkg::result_t         head
);

    rtprx_pkg::result_t                  q_mem_reg [rtprx_pkg::RQ_DEPTH];
    logic [rtprx_pkg::RQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rtprx_pkg::RQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rtprx_pkg::RQ_CNT_W-1:0]      count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    assign res_full = (count_reg == rtprx_pkg::RQ_CNT_W'(rtprx_pkg::RQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign head     = q_mem_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + rtprx_pkg::RQ_CNT_W'(1);
            2'b01:   count_next = count_reg - rtprx_pkg::RQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rtp_receive_statistics_core.sv
// Top level of the RTP receive statistics block with its configuration register.
//
// Usage: events enter through a queue-style port. A beat is taken at a rising
// edge where push is high and full is low; operation selects a data packet
// (seq_num, rtp_timestamp, now_sec, now_usec) or a sender report (rtp_timestamp,
// ntp_seconds, ntp_fraction). Every event yields exactly one result beat with the
// statistics after the update. A result is shown on the output ports while empty
// is low and is consumed at an edge where pop is also high.
// Events wait in a two-entry input queue while a multi-cycle sequencer works on
// the previous one, so the input keeps accepting while the sequencer is busy.
// The sequencer steps a data packet through states D1 to D5 and then EMIT
// (sequence, gap, divide by one million for the arrival time and the jitter
// update are spread over its steps) and takes a sender report straight to EMIT.
// It works on one event at a time and takes the next one in the cycle in which
// it pushes the result of the last one.
// If the receiver stops popping, finished results collect in a two-entry result
// queue; when it fills, the sequencer holds its current result and the input
// queue then fills and raises full. Nothing is dropped.
// Reset clears all statistics (minimum gap to 0x7FFFFFFF), empties both queues
// and sets clock_rate to 90000. clock_rate is written over the APB port at
// address 0 and should only change while no event is in flight.

`default_nettype none

module rtp_receive_statistics_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration port.
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [rtprx_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [rtprx_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rtprx_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                       pready,
    // Event input.
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  operation,
    input  wire logic [15:0]                           seq_num,
    input  wire logic [31:0]                           rtp_timestamp,
    input  wire logic [31:0]                           now_sec,
    input  wire logic [19:0]                           now_usec,
    input  wire logic [31:0]                           ntp_seconds,
    input  wire logic [31:0]                           ntp_fraction,
    // Statistics output.
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [31:0]                                highest_ext_seq,
    output logic [31:0]                                total_packets,
    output logic [31:0]                                jitter_x16,
    output logic [31:0]                                min_gap_us,
    output logic [31:0]                                max_gap_us,
    output logic [63:0]                                gap_total_us,
    output logic                                       synced,
    output logic [31:0]                                sync_sec,
    output logic [19:0]                                sync_usec,
    output logic [31:0]                                sync_rtp_ts
);

    logic [rtprx_pkg::CLOCK_RATE_W-1:0]  clock_rate_reg, clock_rate_next;
    logic [rtprx_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                                cfg_write;

    logic                                item_valid;
    rtprx_pkg::in_item_t                 item;
    logic                                item_take;
    logic                                res_push;
    logic                                res_full;
    rtprx_pkg::result_t                  res_new;
    rtprx_pkg::result_t                  res_head;

    // Register index is the word address; a write elsewhere is ignored.
    assign reg_idx   = paddr[rtprx_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        clock_rate_next = clock_rate_reg;
        if (cfg_write && reg_idx == rtprx_pkg::REG_CLOCK_RATE)
        begin
            clock_rate_next = pwdata[rtprx_pkg::CLOCK_RATE_W-1:0];
        end
        if (reg_idx == rtprx_pkg::REG_CLOCK_RATE)
        begin
            prdata = {{(rtprx_pkg::APB_DATA_W - rtprx_pkg::CLOCK_RATE_W){1'b0}}, clock_rate_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg <= rtprx_pkg::CLOCK_RATE_RESET;
        end
        else
        begin
            clock_rate_reg <= clock_rate_next;
        end
    end

    rtprx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .seq_num       (seq_num),
        .rtp_timestamp (rtp_timestamp),
        .now_sec       (now_sec),
        .now_usec      (now_usec),
        .ntp_seconds   (ntp_seconds),
        .ntp_fraction  (ntp_fraction),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    rtprx_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .clock_rate (clock_rate_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_push   (res_push),
        .res_full   (res_full),
        .result     (res_new)
    );

    rtprx_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res_in   (res_new),
        .empty    (empty),
        .pop      (pop),
        .head     (res_head)
    );

    assign highest_ext_seq = res_head.highest_ext_seq;
    assign total_packets   = res_head.total_packets;
    assign jitter_x16      = res_head.jitter_x16;
    assign min_gap_us      = res_head.min_gap_us;
    assign max_gap_us      = res_head.max_gap_us;
    assign gap_total_us    = res_head.gap_total_us;
    assign synced          = res_head.synced;
    assign sync_sec        = res_head.sync_sec;
    assign sync_usec       = res_head.sync_usec;
    assign sync_rtp_ts     = res_head.sync_rtp_ts;

endmodule

`default_nettype wire

// File: test/rtp_stats_checker.sv
// Watches the event and statistics ports, predicts each statistics beat and compares it.
module rtp_stats_checker
    import rtprx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  push,
    input  logic                  full,
    input  logic                  operation,
    input  logic [15:0]           seq_num,
    input  logic [31:0]           rtp_timestamp,
    input  logic [31:0]           now_sec,
    input  logic [19:0]           now_usec,
    input  logic [31:0]           ntp_seconds,
    input  logic [31:0]           ntp_fraction,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [31:0]           highest_ext_seq,
    input  logic [31:0]           total_packets,
    input  logic [31:0]           jitter_x16,
    input  logic [31:0]           min_gap_us,
    input  logic [31:0]           max_gap_us,
    input  logic [63:0]           gap_total_us,
    input  logic                  synced,
    input  logic [31:0]           sync_sec,
    input  logic [19:0]           sync_usec,
    input  logic [31:0]           sync_rtp_ts,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 30;

    logic [CLOCK_RATE_W-1:0] rate;
    logic                    seq_seen;
    logic [31:0]             ext_seq;
    logic [31:0]             packets;
    logic [31:0]             prev_transit;
    logic                    transit_seen;
    logic [31:0]             prev_ts;
    logic [31:0]             jitter;
    logic [31:0]             last_sec;
    logic [19:0]             last_usec;
    logic                    arrival_seen;
    logic [31:0]             gap_min;
    logic [31:0]             gap_max;
    logic [63:0]             gap_sum;
    logic                    sync_flag;
    logic [31:0]             sync_seconds;
    logic [19:0]             sync_micros;
    logic [31:0]             sync_ts;

    result_t pending_stats[$];
    int      reports;

    function automatic void clear_stats();
        rate         = CLOCK_RATE_RESET;
        seq_seen     = 1'b0;
        ext_seq      = '0;
        packets      = '0;
        prev_transit = '0;
        transit_seen = 1'b0;
        prev_ts      = '0;
        jitter       = '0;
        last_sec     = '0;
        last_usec    = '0;
        arrival_seen = 1'b0;
        gap_min      = GAP_MIN_RESET;
        gap_max      = '0;
        gap_sum      = '0;
        sync_flag    = 1'b0;
        sync_seconds = '0;
        sync_micros  = '0;
        sync_ts      = '0;
    endfunction

    // Applies one event to the predicted statistics and returns the beat it yields.
    function automatic result_t update_stream_stats(input in_item_t ev);
        logic [31:0] cycle_base;
        logic [31:0] candidate;
        logic [31:0] ahead;
        logic [31:0] gap;
        logic [31:0] arrival;
        logic [31:0] transit;
        logic [31:0] delta;
        logic [31:0] magnitude;
        logic [15:0] old_low;
        logic [63:0] frac;
        logic [63:0] acc;
        result_t     r;
        if (ev.kind == KIND_DATA) begin
            if (!seq_seen) begin
                ext_seq  = {16'h0, ev.seq_num};
                seq_seen = 1'b1;
            end
            cycle_base = {ext_seq[31:16], 16'h0};
            old_low    = ext_seq[15:0];
            if (old_low > ev.seq_num && (old_low - ev.seq_num) > SEQ_WRAP_THRESH)
                cycle_base = cycle_base + 32'h0001_0000;
            candidate = cycle_base | {16'h0, ev.seq_num};
            ahead     = candidate - ext_seq;
            if (ahead != 32'h0 && !ahead[31])
                ext_seq = candidate;
            packets = packets + 32'd1;

            if (arrival_seen) begin
                gap = (ev.now_sec - last_sec) * 32'd1000000
                    + ({12'h0, ev.now_usec} - {12'h0, last_usec});
                if (gap > gap_max)
                    gap_max = gap;
                if (gap < gap_min)
                    gap_min = gap;
                gap_sum = gap_sum + {32'h0, gap};
            end
            last_sec     = ev.now_sec;
            last_usec    = ev.now_usec;
            arrival_seen = 1'b1;

            // A repeated timestamp leaves the jitter estimate alone.
            if (ev.rtp_timestamp != prev_ts) begin
                frac    = ({44'h0, rate} * {44'h0, ev.now_usec} + 64'd500000) / 64'd1000000;
                arrival = {12'h0, rate} * ev.now_sec + frac[31:0];
                transit = arrival - ev.rtp_timestamp;
                if (!transit_seen) begin
                    prev_transit = transit;
                    transit_seen = 1'b1;
                end
                delta        = transit - prev_transit;
                prev_transit = transit;
                magnitude    = delta[31] ? (32'h0 - delta) : delta;
                acc = {32'h0, jitter} + {32'h0, magnitude} - (({32'h0, jitter} + 64'd8) >> 4);
                jitter = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            end
            prev_ts = ev.rtp_timestamp;
        end else begin
            sync_ts      = ev.rtp_timestamp;
            sync_seconds = ev.ntp_seconds - NTP_UNIX_OFFSET;
            acc          = ({32'h0, ev.ntp_fraction} * 64'd15625 + 64'h0200_0000) >> 26;
            sync_micros  = acc[19:0];
            sync_flag    = 1'b1;
        end
        r.highest_ext_seq = ext_seq;
        r.total_packets   = packets;
        r.jitter_x16      = jitter;
        r.min_gap_us      = gap_min;
        r.max_gap_us      = gap_max;
        r.gap_total_us    = gap_sum;
        r.synced          = sync_flag;
        r.sync_sec        = sync_seconds;
        r.sync_usec       = sync_micros;
        r.sync_rtp_ts     = sync_ts;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        in_item_t ev;
        result_t  want;
        if (!rst_n) begin
            clear_stats();
            pending_stats.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
                && paddr[APB_ADDR_W-1:2] == REG_CLOCK_RATE)
                rate = pwdata[CLOCK_RATE_W-1:0];

            if (pop && !empty) begin
                if (pending_stats.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t ns: statistics beat with none expected, expected none, actual total_packets 0x%0h",
                                 $time, total_packets);
                    end
                end else begin
                    want = pending_stats.pop_front();
                    checked++;
                    check_field("highest_ext_seq", want.highest_ext_seq, highest_ext_seq);
                    check_field("total_packets", want.total_packets, total_packets);
                    check_field("jitter_x16", want.jitter_x16, jitter_x16);
                    check_field("min_gap_us", want.min_gap_us, min_gap_us);
                    check_field("max_gap_us", want.max_gap_us, max_gap_us);
                    check_field("gap_total_us", want.gap_total_us, gap_total_us);
                    check_field("synced", want.synced, synced);
                    check_field("sync_sec", want.sync_sec, sync_sec);
                    check_field("sync_usec", want.sync_usec, sync_usec);
                    check_field("sync_rtp_ts", want.sync_rtp_ts, sync_rtp_ts);
                end
            end

            if (push && !full) begin
                ev.kind          = kind_t'(operation);
                ev.seq_num       = seq_num;
                ev.rtp_timestamp = rtp_timestamp;
                ev.now_sec       = now_sec;
                ev.now_usec      = now_usec;
                ev.ntp_seconds   = ntp_seconds;
                ev.ntp_fraction  = ntp_fraction;
                pending_stats.push_back(update_stream_stats(ev));
            end
        end
        pending = pending_stats.size();
    end

endmodule

// File: test/tb_rtp_receive_statistics_core.sv
// Stimulus and verdict for the RTP receive statistics block.
module tb_rtp_receive_statistics_core;
    import rtprx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Random beats per phase; eight phases give about 1600 events.
    localparam int ITEMS_PER_PHASE = 200;
    // Cycles to watch for stray beats once everything has come back.
    localparam int SETTLE_CYCLES = 20;
    // A register index with nothing behind it; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'd1;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_FROZEN
    } stall_mode_e;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    logic        push;
    wire         full;
    logic        operation;
    logic [15:0] seq_num;
    logic [31:0] rtp_timestamp;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
    logic [31:0] ntp_seconds;
    logic [31:0] ntp_fraction;

    wire         empty;
    logic        pop;
    wire  [31:0] highest_ext_seq;
    wire  [31:0] total_packets;
    wire  [31:0] jitter_x16;
    wire  [31:0] min_gap_us;
    wire  [31:0] max_gap_us;
    wire  [63:0] gap_total_us;
    wire         synced;
    wire  [31:0] sync_sec;
    wire  [19:0] sync_usec;
    wire  [31:0] sync_rtp_ts;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping for the closing summary.
    int n_data;
    int n_reports;
    int n_settings;

    // The clock_rate the block should be using, so that generated timestamps
    // advance at a believable pace.
    logic [CLOCK_RATE_W-1:0] rate_now;

    // State of the well-formed packet stream that most random beats follow.
    logic [15:0] stream_seq;
    logic [31:0] stream_ts;
    logic [31:0] stream_sec;
    int unsigned stream_usec;

    rtp_receive_statistics_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .seq_num         (seq_num),
        .rtp_timestamp   (rtp_timestamp),
        .now_sec         (now_sec),
        .now_usec        (now_usec),
        .ntp_seconds     (ntp_seconds),
        .ntp_fraction    (ntp_fraction),
        .empty           (empty),
        .pop             (pop),
        .highest_ext_seq (highest_ext_seq),
        .total_packets   (total_packets),
        .jitter_x16      (jitter_x16),
        .min_gap_us      (min_gap_us),
        .max_gap_us      (max_gap_us),
        .gap_total_us    (gap_total_us),
        .synced          (synced),
        .sync_sec        (sync_sec),
        .sync_usec       (sync_usec),
        .sync_rtp_ts     (sync_rtp_ts)
    );

    // The checker sees the same pins as the block and does all prediction and
    // comparison; this module only drives stimulus and reads its counts.
    rtp_stats_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .seq_num         (seq_num),
        .rtp_timestamp   (rtp_timestamp),
        .now_sec         (now_sec),
        .now_usec        (now_usec),
        .ntp_seconds     (ntp_seconds),
        .ntp_fraction    (ntp_fraction),
        .empty           (empty),
        .pop             (pop),
        .highest_ext_seq (highest_ext_seq),
        .total_packets   (total_packets),
        .jitter_x16      (jitter_x16),
        .min_gap_us      (min_gap_us),
        .max_gap_us      (max_gap_us),
        .gap_total_us    (gap_total_us),
        .synced          (synced),
        .sync_sec        (sync_sec),
        .sync_usec       (sync_usec),
        .sync_rtp_ts     (sync_rtp_ts),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // The slowest correct run stays well under a millisecond, so five
    // milliseconds only trips when beats stop coming back.
    initial
    begin
        #(5_000_000);
        $display("timeout with %0d statistics beats still outstanding", pending);
        $display("status: fail");
        $finish;
    end

    // One APB write: a setup cycle, then an access cycle that completes at
    // the first rising edge where pready is high.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] word);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Presents one event and returns once the block has taken the beat. The
    // push line is left high so that a following call continues the burst
    // without a bubble.
    task automatic send_event(input in_item_t ev);
        @(negedge clk);
        push          <= 1'b1;
        operation     <= ev.kind;
        seq_num       <= ev.seq_num;
        rtp_timestamp <= ev.rtp_timestamp;
        now_sec       <= ev.now_sec;
        now_usec      <= ev.now_usec;
        ntp_seconds   <= ev.ntp_seconds;
        ntp_fraction  <= ev.ntp_fraction;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (ev.kind == KIND_DATA)
            n_data++;
        else
            n_reports++;
    endtask

    task automatic send_data(input logic [15:0] seq, input logic [31:0] ts,
                             input logic [31:0] sec, input logic [19:0] usec);
        in_item_t ev;
        ev               = '0;
        ev.kind          = KIND_DATA;
        ev.seq_num       = seq;
        ev.rtp_timestamp = ts;
        ev.now_sec       = sec;
        ev.now_usec      = usec;
        send_event(ev);
    endtask

    task automatic send_report(input logic [31:0] ts, input logic [31:0] nsec,
                               input logic [31:0] nfrac);
        in_item_t ev;
        ev               = '0;
        ev.kind          = KIND_SR;
        ev.rtp_timestamp = ts;
        ev.ntp_seconds   = nsec;
        ev.ntp_fraction  = nfrac;
        send_event(ev);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // Holds the sender back until every predicted beat has been popped.
    // Sampling at the falling edge sees the checker settled for the cycle.
    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly a plausible stream: sequence numbers step by one with some loss
    // and reordering, arrival times move forward by about a frame, and the
    // timestamp follows the clock rate. Sender reports are mixed in, and a
    // small share of beats are pure noise across every field.
    function automatic in_item_t next_stream_event();
        in_item_t    ev;
        int unsigned pick;
        int unsigned gap_us;
        ev   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            ev.kind          = kind_t'($urandom_range(0, 1));
            ev.seq_num       = 16'($urandom);
            ev.rtp_timestamp = $urandom;
            ev.now_sec       = $urandom;
            ev.now_usec      = 20'($urandom_range(0, 999999));
            ev.ntp_seconds   = $urandom;
            ev.ntp_fraction  = $urandom;
        end else if (pick < 18) begin
            ev.kind          = KIND_SR;
            ev.rtp_timestamp = stream_ts + 32'($urandom_range(0, 3000));
            ev.ntp_seconds   = $urandom;
            ev.ntp_fraction  = $urandom;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                stream_seq = 16'($urandom);
            else if (pick < 12)
                stream_seq = stream_seq + 16'($urandom_range(0, 6)) - 16'd2;
            else
                stream_seq = stream_seq + 16'd1;

            if ($urandom_range(0, 19) == 0)
                gap_us = $urandom_range(0, 3_000_000);
            else
                gap_us = $urandom_range(15000, 25000);
            stream_usec = stream_usec + gap_us;
            stream_sec  = stream_sec + 32'(stream_usec / 1000000);
            stream_usec = stream_usec % 1000000;

            // Every tenth packet or so repeats the timestamp of the one before,
            // which must leave the jitter estimate untouched.
            if ($urandom_range(0, 9) != 0)
                stream_ts = stream_ts + 32'((64'(rate_now) * gap_us) / 64'd1000000)
                          + 32'($urandom_range(0, 200));

            ev.kind          = KIND_DATA;
            ev.seq_num       = stream_seq;
            ev.rtp_timestamp = stream_ts;
            ev.now_sec       = stream_sec;
            ev.now_usec      = 20'(stream_usec);
            ev.ntp_seconds   = $urandom;
            ev.ntp_fraction  = $urandom;
        end
        return ev;
    endfunction

    // One clock_rate setting: optionally write the register while the block is
    // idle, then run random bursts and drain everything before returning.
    task automatic run_phase(input bit write_rate, input logic [31:0] word);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        if (write_rate) begin
            apb_write(REG_CLOCK_RATE, word);
            rate_now = word[CLOCK_RATE_W-1:0];
            n_settings++;
        end
        // Start each stream just below a sequence wrap so that the wrap is
        // crossed by well-formed traffic.
        stream_seq  = 16'hFF00 + 16'($urandom_range(0, 255));
        stream_ts   = $urandom;
        stream_sec  = $urandom;
        stream_usec = $urandom_range(0, 999999);
        sent        = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_event(next_stream_event());
                sent++;
            end
            // Gaps of many lengths land on every step of the sequencer; a
            // zero gap keeps the burst going with push held high.
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0)
                idle_sender(gap);
        end
        idle_sender(1);
        wait_drained();
    endtask

    // Receiver: runs of full-rate popping, coin flips, sparse pops and frozen
    // stretches long enough to fill both queues and raise full.
    initial
    begin : receiver
        stall_mode_e mode;
        int unsigned span;
        int unsigned k;
        pop = 1'b0;
        forever
        begin
            mode = stall_mode_e'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    RX_ALWAYS: pop <= 1'b1;
                    RX_COIN:   pop <= 1'($urandom_range(0, 1));
                    RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
                    default:   pop <= (k >= 40);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        operation     = KIND_DATA;
        seq_num       = '0;
        rtp_timestamp = '0;
        now_sec       = '0;
        now_usec      = '0;
        ntp_seconds   = '0;
        ntp_fraction  = '0;
        n_data        = 0;
        n_reports     = 0;
        n_settings    = 1;
        rate_now      = CLOCK_RATE_RESET;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset clock rate. The first packet carries a
        // zero timestamp, which matches the cleared previous timestamp and so
        // must not touch the jitter.
        send_data(16'hFFF0, 32'd0, 32'd0, 20'd0);
        send_data(16'hFFFF, 32'd3000, 32'd0, 20'd33333);
        // Sequence wrap into the next cycle, then a repeated timestamp.
        send_data(16'h0000, 32'd6000, 32'd0, 20'd66666);
        send_data(16'h0001, 32'd6000, 32'd0, 20'd100000);
        // A late packet from before the wrap and a jump of more than half the
        // sequence space.
        send_data(16'hFFFE, 32'd9000, 32'd0, 20'd133333);
        send_data(16'h8002, 32'd12000, 32'd1, 20'd0);
        // Time running backwards, then the extremes of the arrival time and
        // of the timestamp; the gap arithmetic simply wraps.
        send_data(16'h8003, 32'd15000, 32'd0, 20'd500000);
        send_data(16'h8004, 32'd18000, 32'hFFFF_FFFF, 20'd999999);
        send_data(16'h8005, 32'hFFFF_FFFF, 32'd0, 20'd0);
        // Sender reports: all zero, all ones (rounds up to a full million
        // microseconds), and exactly the Unix epoch with half a second.
        send_report(32'd0, 32'd0, 32'd0);
        send_report(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_report(32'd12345, NTP_UNIX_OFFSET, 32'h8000_0000);
        // Timestamps swinging by half the 32-bit range at a fixed arrival time
        // drive the jitter sum into saturation; a small step then lets it
        // decay from the ceiling.
        for (int i = 0; i < 7; i++)
            send_data(16'h8006 + 16'(i), (i % 2 == 0) ? 32'h0000_1000 : 32'h8000_1000,
                      32'd100, 20'd0);
        send_data(16'h800D, 32'h0000_2000, 32'd100, 20'd0);
        send_data(16'h800E, 32'h0000_3000, 32'd100, 20'd999999);
        idle_sender(1);
        wait_drained();

        run_phase(1'b0, 32'd0);
        run_phase(1'b1, 32'd1000000);
        // A write to an unmapped register must leave clock_rate as it was.
        apb_write(REG_UNMAPPED, $urandom);
        run_phase(1'b0, 32'd0);
        run_phase(1'b1, 32'd1);
        // A zero clock rate is used as given.
        run_phase(1'b1, 32'd0);
        // All ones: the bits above the register are dropped, leaving 0xFFFFF.
        run_phase(1'b1, 32'hFFFF_FFFF);
        run_phase(1'b1, 32'd8000);
        run_phase(1'b1, $urandom);

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("covered %0d data packets and %0d sender reports over %0d clock_rate settings",
                 n_data, n_reports, n_settings);
        $display("statistics beats checked: %0d, field mismatches: %0d", checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
